@@ hw/rtl/assert_macros.svh @@
// Assertion macros included by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define CHK_SAME(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("same-cycle check failed");

// next-cycle implication, disabled while reset is high
`define CHK_NEXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("next-cycle check failed");

`endif

@@ hw/rtl/skic_pkg.sv @@
// Shared constants, types and codes of the sparse kernel convolution core
package skic_pkg;

   // sizing
   localparam int MAX_DIM    = 256;
   localparam int MAX_TAPS   = 16;
   localparam int MAX_OFFSET = 7;

   localparam int DIM_BITS      = $clog2(MAX_DIM);
   localparam int PIX_ADDR_BITS = 2 * DIM_BITS;
   localparam int PIX_DEPTH     = MAX_DIM * MAX_DIM;
   localparam int TAP_BITS      = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
   localparam int CNT_BITS      = $clog2(MAX_TAPS + 1);

   // field widths
   localparam int CMD_W      = 2;
   localparam int COORD_W    = 8;
   localparam int PIX_W      = 8;
   localparam int TIDX_W     = 4;
   localparam int OFF_W      = 4;
   localparam int WEIGHT_W   = 16;
   localparam int DIMCFG_W   = 9;
   localparam int TAPCFG_W   = 5;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 9;
   localparam int FRAC_BITS  = 8;

   // arithmetic widths
   localparam int POS_W  = DIMCFG_W + 1;
   localparam int PROD_W = PIX_W + 1 + WEIGHT_W;
   localparam int ACC_W  = PROD_W + TAP_BITS;

   // command codes
   localparam logic [CMD_W-1:0] CMD_WRITE_PIXEL = 2'd0;
   localparam logic [CMD_W-1:0] CMD_WRITE_TAP   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_COMPUTE     = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_TAP_COUNT    = 2'd2;

   // one kernel tap as held in the tap memory
   typedef struct packed {
      logic signed [OFF_W-1:0]    dx;
      logic signed [OFF_W-1:0]    dy;
      logic signed [WEIGHT_W-1:0] weight;
   } tap_type;

   localparam int TAP_W = $bits(tap_type);

   // per-tap tag that travels with a tap down the pipeline
   typedef struct packed {
      logic valid;
      logic first;
      logic last;
      logic hit;
   } pipe_ctl_type;

endpackage

@@ hw/rtl/skic_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read
module skic_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ABITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [ABITS-1:0] waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [ABITS-1:0] raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ hw/rtl/skic_ctrl.sv @@
// Tap sequencer: walks the tap memory and issues pixel reads
module skic_ctrl (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [skic_pkg::CMD_W-1:0]        cmd,
   input  logic [skic_pkg::COORD_W-1:0]      row,
   input  logic [skic_pkg::COORD_W-1:0]      col,
   input  logic [skic_pkg::DIMCFG_W-1:0]     cfg_width,
   input  logic [skic_pkg::DIMCFG_W-1:0]     cfg_height,
   input  logic [skic_pkg::TAPCFG_W-1:0]     cfg_taps,
   input  logic                              finish,
   output logic                              busy,
   output logic                              tap_re,
   output logic [skic_pkg::TAP_BITS-1:0]     tap_raddr,
   input  skic_pkg::tap_type                 tap_rdata,
   output logic                              pix_re,
   output logic [skic_pkg::PIX_ADDR_BITS-1:0] pix_raddr,
   output skic_pkg::pipe_ctl_type            ctl,
   output logic signed [skic_pkg::WEIGHT_W-1:0] weight,
   output logic [skic_pkg::COORD_W-1:0]      out_row,
   output logic [skic_pkg::COORD_W-1:0]      out_col
);
   import skic_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN
   } state_type;

   function automatic logic signed [OFF_W-1:0] clamp_off(input logic signed [OFF_W-1:0] d);
      logic signed [OFF_W-1:0] r;
      r = d;
      if (d > MAX_OFFSET) begin
         r = OFF_W'(MAX_OFFSET);
      end else if (d < -MAX_OFFSET) begin
         r = OFF_W'(-MAX_OFFSET);
      end
      return r;
   endfunction

   state_type                  state_ff, state_in;
   logic [CNT_BITS-1:0]        idx_ff, idx_in;
   logic [CNT_BITS-1:0]        num_ff, num_in;
   logic                       skip_ff, skip_in;
   logic [COORD_W-1:0]         row_ff, row_in;
   logic [COORD_W-1:0]         col_ff, col_in;
   logic [DIMCFG_W-1:0]        w_ff, w_in;
   logic [DIMCFG_W-1:0]        h_ff, h_in;
   pipe_ctl_type               b_ff, b_in;
   pipe_ctl_type               c_ff, c_in;
   logic signed [WEIGHT_W-1:0] wt_ff, wt_in;

   logic [CNT_BITS-1:0]        n_eff;
   logic signed [OFF_W-1:0]    dxc, dyc;
   logic signed [POS_W-1:0]    x, y;
   logic                       hit;

   // stage B: tap data is back, form the pixel position
   always_comb begin
      dxc = clamp_off(tap_rdata.dx);
      dyc = clamp_off(tap_rdata.dy);
      x   = $signed({{(POS_W - COORD_W){1'b0}}, col_ff})
          + {{(POS_W - OFF_W){dxc[OFF_W-1]}}, dxc};
      y   = $signed({{(POS_W - COORD_W){1'b0}}, row_ff})
          + {{(POS_W - OFF_W){dyc[OFF_W-1]}}, dyc};
      hit = !skip_ff
         && (x >= 0) && (x < $signed({1'b0, w_ff}))
         && (y >= 0) && (y < $signed({1'b0, h_ff}));
   end

   always_comb begin
      if (32'(cfg_taps) > MAX_TAPS) begin
         n_eff = CNT_BITS'(MAX_TAPS);
      end else begin
         n_eff = CNT_BITS'(cfg_taps);
      end
   end

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      num_in   = num_ff;
      skip_in  = skip_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      w_in     = w_ff;
      h_in     = h_ff;
      b_in     = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start && (cmd == CMD_COMPUTE)) begin
               state_in = ST_RUN;
               idx_in   = '0;
               // no taps: one empty pass keeps the pipeline uniform
               num_in   = (n_eff == '0) ? CNT_BITS'(1) : n_eff;
               skip_in  = (n_eff == '0);
               row_in   = row;
               col_in   = col;
               w_in     = (32'(cfg_width) > MAX_DIM) ? DIMCFG_W'(MAX_DIM) : cfg_width;
               h_in     = (32'(cfg_height) > MAX_DIM) ? DIMCFG_W'(MAX_DIM) : cfg_height;
            end
         end
         ST_RUN: begin
            b_in.valid = 1'b1;
            b_in.first = (idx_ff == '0);
            b_in.last  = (idx_ff == num_ff - CNT_BITS'(1));
            idx_in     = idx_ff + CNT_BITS'(1);
            if (b_in.last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (finish) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      c_in       = b_ff;
      c_in.hit   = b_ff.valid && hit;
      wt_in      = tap_rdata.weight;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
         num_ff   <= '0;
         skip_ff  <= 1'b0;
         b_ff     <= '0;
         c_ff     <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         num_ff   <= num_in;
         skip_ff  <= skip_in;
         b_ff     <= b_in;
         c_ff     <= c_in;
      end
      row_ff <= row_in;
      col_ff <= col_in;
      w_ff   <= w_in;
      h_ff   <= h_in;
      wt_ff  <= wt_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign tap_re    = (state_ff == ST_RUN);
   assign tap_raddr = idx_ff[TAP_BITS-1:0];
   assign pix_re    = b_ff.valid;
   assign pix_raddr = {DIM_BITS'(unsigned'(y)), DIM_BITS'(unsigned'(x))};
   assign ctl       = c_ff;
   assign weight    = wt_ff;
   assign out_row   = row_ff;
   assign out_col   = col_ff;

endmodule

@@ hw/rtl/skic_accum.sv @@
// Multiply-accumulate and clamp stage for the convolution sum
module skic_accum (
   input  logic                                 clock,
   input  logic                                 reset,
   input  skic_pkg::pipe_ctl_type               ctl,
   input  logic [skic_pkg::PIX_W-1:0]           pixel,
   input  logic signed [skic_pkg::WEIGHT_W-1:0] weight,
   output logic                                 finish,
   output logic                                 rsp_valid,
   output logic [skic_pkg::PIX_W-1:0]           value
);
   import skic_pkg::*;

   pipe_ctl_type             d_ff;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0]  acc_ff, sum;
   logic [PIX_W-1:0]         value_ff, value_in;
   logic                     valid_ff;

   always_comb begin
      // off-image taps contribute nothing
      if (ctl.hit) begin
         prod_in = $signed({1'b0, pixel}) * weight;
      end else begin
         prod_in = '0;
      end
      sum     = (d_ff.first ? ACC_W'(0) : acc_ff) + ACC_W'(prod_ff);
      if (sum[ACC_W-1]) begin
         value_in = '0;
      end else if (|sum[ACC_W-2:FRAC_BITS+PIX_W]) begin
         value_in = '1;
      end else begin
         value_in = sum[FRAC_BITS+PIX_W-1:FRAC_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_ff     <= '0;
         valid_ff <= 1'b0;
      end else begin
         d_ff     <= ctl;
         valid_ff <= d_ff.valid && d_ff.last;
      end
      prod_ff <= prod_in;
      if (d_ff.valid) begin
         acc_ff <= sum;
      end
      if (d_ff.valid && d_ff.last) begin
         value_ff <= value_in;
      end
   end

   assign finish    = d_ff.valid && d_ff.last;
   assign rsp_valid = valid_ff;
   assign value     = value_ff;

endmodule

@@ hw/rtl/sparse_kernel_image_convolution_core.sv @@
// Top level of the sparse kernel convolution core over a stored greyscale image
//
//   channel   direction  handshake            payload
//   req_      in         start / busy         command, row, col, pixel, tap fields
//   rsp_      out        rsp_valid strobe     out_row, out_col, out_value
//   csr_      in         csr_valid/csr_ready  csr_index, csr_wdata
//
// Pixel and tap writes are taken at acceptance: busy stays low and the next
// transaction may follow at once. A compute transaction walks the taps one per
// cycle through the tap memory, then the pixel memory and a multiply-accumulate
// pipeline; its result strobe and value are registered from the last tap's sum.
// busy drops in the strobe cycle. reset is synchronous and clears control state,
// never the memories.
module sparse_kernel_image_convolution_core (
   input  logic                                  clock,
   input  logic                                  reset,
   // request channel
   input  logic                                  start,
   output logic                                  busy,
   input  logic [skic_pkg::CMD_W-1:0]            req_command,
   input  logic [skic_pkg::COORD_W-1:0]          req_row,
   input  logic [skic_pkg::COORD_W-1:0]          req_col,
   input  logic [skic_pkg::PIX_W-1:0]            req_pixel_value,
   input  logic [skic_pkg::TIDX_W-1:0]           req_tap_index,
   input  logic signed [skic_pkg::OFF_W-1:0]     req_tap_dx,
   input  logic signed [skic_pkg::OFF_W-1:0]     req_tap_dy,
   input  logic signed [skic_pkg::WEIGHT_W-1:0]  req_tap_weight,
   // response channel
   output logic                                  rsp_valid,
   output logic [skic_pkg::COORD_W-1:0]          rsp_out_row,
   output logic [skic_pkg::COORD_W-1:0]          rsp_out_col,
   output logic [skic_pkg::PIX_W-1:0]            rsp_out_value,
   // register write channel
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [skic_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [skic_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import skic_pkg::*;

   logic [DIMCFG_W-1:0]       width_ff;
   logic [DIMCFG_W-1:0]       height_ff;
   logic [TAPCFG_W-1:0]       taps_ff;

   logic                      accept;
   logic                      pix_we, tap_we;
   logic [PIX_ADDR_BITS-1:0]  pix_waddr;
   logic [TAP_BITS-1:0]       tap_waddr;
   tap_type                   tap_wdata;

   logic                      tap_re, pix_re;
   logic [TAP_BITS-1:0]       tap_raddr;
   logic [PIX_ADDR_BITS-1:0]  pix_raddr;
   logic [TAP_W-1:0]          tap_rword;
   tap_type                   tap_rdata;
   logic [PIX_W-1:0]          pix_rdata;

   pipe_ctl_type              ctl;
   logic signed [WEIGHT_W-1:0] weight;
   logic                      finish;

   // register file; unknown indexes fall through and are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DIMCFG_W'(MAX_DIM);
         height_ff <= DIMCFG_W'(MAX_DIM);
         taps_ff   <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_IMAGE_WIDTH:  width_ff  <= csr_wdata[DIMCFG_W-1:0];
            REG_IMAGE_HEIGHT: height_ff <= csr_wdata[DIMCFG_W-1:0];
            REG_TAP_COUNT:    taps_ff   <= csr_wdata[TAPCFG_W-1:0];
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;

   // write commands go straight into the memories at acceptance
   assign accept = start && !busy;

   always_comb begin
      pix_we = accept && (req_command == CMD_WRITE_PIXEL)
            && (32'(req_row) < MAX_DIM) && (32'(req_col) < MAX_DIM);
      tap_we = accept && (req_command == CMD_WRITE_TAP)
            && (32'(req_tap_index) < MAX_TAPS);
      pix_waddr = {DIM_BITS'(req_row), DIM_BITS'(req_col)};
      tap_waddr = TAP_BITS'(req_tap_index);
      tap_wdata.dx     = req_tap_dx;
      tap_wdata.dy     = req_tap_dy;
      tap_wdata.weight = req_tap_weight;
   end

   skic_ram #(
      .WIDTH (PIX_W),
      .DEPTH (PIX_DEPTH)
   ) u_pixel_ram (
      .clock (clock),
      .we    (pix_we),
      .waddr (pix_waddr),
      .wdata (req_pixel_value),
      .re    (pix_re),
      .raddr (pix_raddr),
      .rdata (pix_rdata)
   );

   skic_ram #(
      .WIDTH (TAP_W),
      .DEPTH (MAX_TAPS)
   ) u_tap_ram (
      .clock (clock),
      .we    (tap_we),
      .waddr (tap_waddr),
      .wdata (tap_wdata),
      .re    (tap_re),
      .raddr (tap_raddr),
      .rdata (tap_rword)
   );

   assign tap_rdata = tap_rword;

   skic_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .cmd        (req_command),
      .row        (req_row),
      .col        (req_col),
      .cfg_width  (width_ff),
      .cfg_height (height_ff),
      .cfg_taps   (taps_ff),
      .finish     (finish),
      .busy       (busy),
      .tap_re     (tap_re),
      .tap_raddr  (tap_raddr),
      .tap_rdata  (tap_rdata),
      .pix_re     (pix_re),
      .pix_raddr  (pix_raddr),
      .ctl        (ctl),
      .weight     (weight),
      .out_row    (rsp_out_row),
      .out_col    (rsp_out_col)
   );

   skic_accum u_accum (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .pixel     (pix_rdata),
      .weight    (weight),
      .finish    (finish),
      .rsp_valid (rsp_valid),
      .value     (rsp_out_value)
   );

endmodule

@@ hw/rtl/skic_checker.sv @@
// Port-level checks on the convolution core and their binding
`include "assert_macros.svh"

module skic_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         start,
   input logic                         busy,
   input logic [skic_pkg::CMD_W-1:0]   req_command,
   input logic                         rsp_valid
);
   import skic_pkg::*;

   logic compute_acc;
   logic write_acc;

   assign compute_acc = start && !busy && (req_command == CMD_COMPUTE);
   assign write_acc   = start && !busy && (req_command != CMD_COMPUTE);

   `CHK_NEXT(a_compute_busy, clock, reset, compute_acc, busy)
   `CHK_NEXT(a_write_free, clock, reset, write_acc, !busy)
   `CHK_SAME(a_rsp_idle, clock, reset, rsp_valid, !busy)
   `CHK_SAME(a_rsp_after_busy, clock, reset, rsp_valid, $past(busy))
   `CHK_NEXT(a_rsp_single, clock, reset, rsp_valid, !rsp_valid)

endmodule

bind sparse_kernel_image_convolution_core skic_checker u_skic_checker (
   .clock       (clock),
   .reset       (reset),
   .start       (start),
   .busy        (busy),
   .req_command (req_command),
   .rsp_valid   (rsp_valid)
);

@@ dv/tb_sparse_kernel_image_convolution_core.sv @@
// Testbench for the sparse kernel convolution core: directed and random command traffic checked by a scoreboard
module tb_sparse_kernel_image_convolution_core;
   import skic_pkg::*;

   // command with no meaning; the core must swallow it without a response
   localparam logic [CMD_W-1:0]     CMD_UNUSED   = 2'd3;
   // register index that maps to nothing
   localparam logic [CSR_IDX_W-1:0] REG_UNMAPPED = 2'd3;
   // cycles with no transaction of any kind before the run is declared hung
   localparam int WATCHDOG_LIMIT = 2000;
   // quiet time after the last response before a register write; covers the
   // longest compute with margin
   localparam int SETTLE_CYCLES  = 24;

   typedef struct packed {
      logic [CMD_W-1:0]           command;
      logic [COORD_W-1:0]         row;
      logic [COORD_W-1:0]         col;
      logic [PIX_W-1:0]           pixel_value;
      logic [TIDX_W-1:0]          tap_index;
      logic signed [OFF_W-1:0]    tap_dx;
      logic signed [OFF_W-1:0]    tap_dy;
      logic signed [WEIGHT_W-1:0] tap_weight;
   } conv_request_type;

   typedef struct packed {
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
      logic [PIX_W-1:0]   value;
   } conv_pixel_type;

   // Mirror of the core: image store, tap tables and registers, updated on
   // every accepted transaction, plus the queue of filtered pixels still owed.
   class conv_scoreboard_type;
      logic [PIX_W-1:0]           pix_mem    [PIX_DEPTH];
      logic signed [OFF_W-1:0]    dx_mem     [MAX_TAPS];
      logic signed [OFF_W-1:0]    dy_mem     [MAX_TAPS];
      logic signed [WEIGHT_W-1:0] weight_mem [MAX_TAPS];
      logic [DIMCFG_W-1:0]        image_width  = 9'd256;
      logic [DIMCFG_W-1:0]        image_height = 9'd256;
      logic [TAPCFG_W-1:0]        tap_count    = 5'd0;
      conv_pixel_type             owed_pixels [$];
      int                         error_count  = 0;

      static function int clamp_offset(logic signed [OFF_W-1:0] d);
         int v;
         v = d;
         if (v > MAX_OFFSET) return MAX_OFFSET;
         if (v < -MAX_OFFSET) return -MAX_OFFSET;
         return v;
      endfunction

      task report(string msg);
         $display("[%0t] mismatch: %s", $time, msg);
         error_count++;
      endtask

      function int pending();
         return owed_pixels.size();
      endfunction

      // sum of pixels times Q8.8 weights over the taps in use, off-image taps skipped, clamped to a byte
      function logic [PIX_W-1:0] filter_at(logic [COORD_W-1:0] row, logic [COORD_W-1:0] col);
         int eff_w, eff_h, taps, x, y, acc;
         eff_w = (image_width > MAX_DIM) ? MAX_DIM : int'(image_width);
         eff_h = (image_height > MAX_DIM) ? MAX_DIM : int'(image_height);
         taps  = (tap_count > MAX_TAPS) ? MAX_TAPS : int'(tap_count);
         acc   = 0;
         for (int t = 0; t < taps; t++) begin
            x = int'(col) + clamp_offset(dx_mem[t]);
            y = int'(row) + clamp_offset(dy_mem[t]);
            if (x >= 0 && x < eff_w && y >= 0 && y < eff_h)
               acc += int'(pix_mem[y * MAX_DIM + x]) * int'(weight_mem[t]);
         end
         if (acc < 0) return '0;
         if ((acc >>> FRAC_BITS) > 255) return 8'd255;
         return PIX_W'(acc >>> FRAC_BITS);
      endfunction

      function void note_reg_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            REG_IMAGE_WIDTH:  image_width  = data;
            REG_IMAGE_HEIGHT: image_height = data;
            REG_TAP_COUNT:    tap_count    = data[TAPCFG_W-1:0];
            default: ;
         endcase
      endfunction

      function void note_request(conv_request_type r);
         conv_pixel_type p;
         case (r.command)
            CMD_WRITE_PIXEL: pix_mem[int'(r.row) * MAX_DIM + int'(r.col)] = r.pixel_value;
            CMD_WRITE_TAP: begin
               dx_mem[r.tap_index]     = r.tap_dx;
               dy_mem[r.tap_index]     = r.tap_dy;
               weight_mem[r.tap_index] = r.tap_weight;
            end
            CMD_COMPUTE: begin
               p.row   = r.row;
               p.col   = r.col;
               p.value = filter_at(r.row, r.col);
               owed_pixels.push_back(p);
            end
            default: ;
         endcase
      endfunction

      task check_result(logic [COORD_W-1:0] row, logic [COORD_W-1:0] col,
                        logic [PIX_W-1:0] value);
         conv_pixel_type e;
         if (owed_pixels.size() == 0) begin
            report($sformatf("response (%0d,%0d)=%0d with no compute outstanding",
                             row, col, value));
         end else begin
            e = owed_pixels.pop_front();
            if (row !== e.row)
               report($sformatf("out_row %0d, want %0d", row, e.row));
            if (col !== e.col)
               report($sformatf("out_col %0d, want %0d", col, e.col));
            if (value !== e.value)
               report($sformatf("out_value %0d at (%0d,%0d), want %0d",
                                value, e.row, e.col, e.value));
         end
      endtask
   endclass

   logic                       clock = 1'b0;
   logic                       reset;
   logic                       start;
   logic                       busy;
   conv_request_type           req_bus;
   logic                       rsp_valid;
   logic [COORD_W-1:0]         rsp_out_row;
   logic [COORD_W-1:0]         rsp_out_col;
   logic [PIX_W-1:0]           rsp_out_value;
   logic                       csr_valid;
   logic                       csr_ready;
   logic [CSR_IDX_W-1:0]       csr_index;
   logic [CSR_DATA_W-1:0]      csr_wdata;

   conv_scoreboard_type sb;

   // Stimulus-side view of the core, kept as transactions are issued (not
   // when accepted) so that compute requests never touch an unwritten pixel.
   bit                         pix_written [PIX_DEPTH];
   logic signed [OFF_W-1:0]    plan_dx [MAX_TAPS];
   logic signed [OFF_W-1:0]    plan_dy [MAX_TAPS];
   int                         plan_w = MAX_DIM;
   int                         plan_h = MAX_DIM;
   int                         plan_n = 0;
   int                         items_sent = 0;
   bit                         gaps_on = 1'b0;
   int                         quiet_cycles = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   sparse_kernel_image_convolution_core uut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_command     (req_bus.command),
      .req_row         (req_bus.row),
      .req_col         (req_bus.col),
      .req_pixel_value (req_bus.pixel_value),
      .req_tap_index   (req_bus.tap_index),
      .req_tap_dx      (req_bus.tap_dx),
      .req_tap_dy      (req_bus.tap_dy),
      .req_tap_weight  (req_bus.tap_weight),
      .rsp_valid       (rsp_valid),
      .rsp_out_row     (rsp_out_row),
      .rsp_out_col     (rsp_out_col),
      .rsp_out_value   (rsp_out_value),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   // Monitor: everything is sampled at the rising edge, before this edge's
   // updates land, so the values seen are the ones the core acted upon.
   // The response check runs first; a compute accepted in the same cycle is
   // always younger than the response being strobed.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid)
            sb.check_result(rsp_out_row, rsp_out_col, rsp_out_value);
         if (start && !busy)
            sb.note_request(req_bus);
         if (csr_valid && csr_ready)
            sb.note_reg_write(csr_index, csr_wdata);
         if (rsp_valid || (start && !busy) || (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[sparse_kernel_image_convolution_core] ERROR");
            $finish;
         end
      end
   end

   function automatic logic [PIX_W-1:0] random_pixel();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return 8'd255;
         default: return PIX_W'($urandom);
      endcase
   endfunction

   function automatic logic signed [WEIGHT_W-1:0] random_weight();
      case ($urandom_range(0, 7))
         0:       return 16'sh7FFF;
         1:       return 16'sh8000;
         2, 3:    return WEIGHT_W'($urandom_range(0, 1024) - 512);
         default: return WEIGHT_W'($urandom);
      endcase
   endfunction

   // every field random; callers overwrite what the command uses
   function automatic conv_request_type random_request();
      conv_request_type r;
      r.command     = CMD_W'($urandom);
      r.row         = COORD_W'($urandom);
      r.col         = COORD_W'($urandom);
      r.pixel_value = PIX_W'($urandom);
      r.tap_index   = TIDX_W'($urandom);
      r.tap_dx      = OFF_W'($urandom);
      r.tap_dy      = OFF_W'($urandom);
      r.tap_weight  = WEIGHT_W'($urandom);
      return r;
   endfunction

   // coordinate mostly inside the image in use, clustered at the borders of
   // large images so that their pixels get reused
   function automatic int pick_coord(int lim);
      if (lim == 0 || $urandom_range(0, 9) < 3) return $urandom_range(0, 255);
      if (lim > 32 && $urandom_range(0, 3) != 0)
         return ($urandom_range(0, 1) != 0) ? $urandom_range(0, 15)
                                            : $urandom_range(lim - 16, lim - 1);
      return $urandom_range(0, lim - 1);
   endfunction

   task automatic idle(input int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Present one transaction and hold it until the core takes it. start is
   // left high on return, unless a random idle gap follows, so back-to-back transactions need no re-arm.
   task automatic send_request(input conv_request_type r);
      req_bus <= r;
      start   <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (gaps_on && $urandom_range(0, 2) == 0)
         idle($urandom_range(1, 17));
   endtask

   // hold off the sender until every owed response has been seen
   task automatic settle();
      start <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic issue_pixel(input int row, input int col, input logic [PIX_W-1:0] value);
      conv_request_type r;
      r             = random_request();
      r.command     = CMD_WRITE_PIXEL;
      r.row         = COORD_W'(row);
      r.col         = COORD_W'(col);
      r.pixel_value = value;
      pix_written[row * MAX_DIM + col] = 1'b1;
      send_request(r);
      items_sent++;
   endtask

   task automatic issue_tap(input int idx, input logic signed [OFF_W-1:0] dx,
                            input logic signed [OFF_W-1:0] dy,
                            input logic signed [WEIGHT_W-1:0] weight);
      conv_request_type r;
      r            = random_request();
      r.command    = CMD_WRITE_TAP;
      r.tap_index  = TIDX_W'(idx);
      r.tap_dx     = dx;
      r.tap_dy     = dy;
      r.tap_weight = weight;
      plan_dx[idx] = dx;
      plan_dy[idx] = dy;
      send_request(r);
      items_sent++;
   endtask

   // Compute at (row, col), first filling any in-image pixel the taps will
   // read that has not been written yet.
   task automatic issue_compute(input int row, input int col);
      int x, y;
      conv_request_type r;
      for (int t = 0; t < plan_n; t++) begin
         x = col + conv_scoreboard_type::clamp_offset(plan_dx[t]);
         y = row + conv_scoreboard_type::clamp_offset(plan_dy[t]);
         if (x >= 0 && x < plan_w && y >= 0 && y < plan_h && !pix_written[y * MAX_DIM + x])
            issue_pixel(y, x, random_pixel());
      end
      r         = random_request();
      r.command = CMD_COMPUTE;
      r.row     = COORD_W'(row);
      r.col     = COORD_W'(col);
      send_request(r);
      items_sent++;
   endtask

   task automatic wait_csr();
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // Register writes only with the core idle: drain, then let any pixel or
   // tap write still in flight retire. csr_valid stays high across the chain.
   task automatic program_regs(input logic [CSR_DATA_W-1:0] w, input logic [CSR_DATA_W-1:0] h,
                               input logic [CSR_DATA_W-1:0] n, input bit with_unmapped);
      settle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      while (busy) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= REG_IMAGE_WIDTH;
      csr_wdata <= w;
      wait_csr();
      csr_index <= REG_IMAGE_HEIGHT;
      csr_wdata <= h;
      wait_csr();
      csr_index <= REG_TAP_COUNT;
      csr_wdata <= n;
      wait_csr();
      if (with_unmapped) begin
         csr_index <= REG_UNMAPPED;
         csr_wdata <= CSR_DATA_W'($urandom);
         wait_csr();
      end
      csr_valid <= 1'b0;
      plan_w = (w > MAX_DIM) ? MAX_DIM : int'(w);
      plan_h = (h > MAX_DIM) ? MAX_DIM : int'(h);
      plan_n = (n[TAPCFG_W-1:0] > MAX_TAPS) ? MAX_TAPS : int'(n[TAPCFG_W-1:0]);
   endtask

   // Mostly computes with their pixel fills; tap rewrites, stray pixel writes,
   // unknown commands and the odd full drain make up the rest.
   task automatic random_items(input int budget, input bit idling);
      int sel;
      conv_request_type r;
      items_sent = 0;
      gaps_on    = idling;
      while (items_sent < budget) begin
         if (idling && $urandom_range(0, 39) == 0) gaps_on = !gaps_on;
         sel = $urandom_range(0, 99);
         if (sel < 55) begin
            issue_compute(pick_coord(plan_h), pick_coord(plan_w));
         end else if (sel < 70) begin
            issue_tap($urandom_range(0, MAX_TAPS - 1), OFF_W'($urandom), OFF_W'($urandom),
                      random_weight());
         end else if (sel < 92) begin
            issue_pixel(pick_coord(plan_h), pick_coord(plan_w), random_pixel());
         end else if (sel < 97) begin
            r         = random_request();
            r.command = CMD_UNUSED;
            send_request(r);
         end else begin
            settle();
         end
      end
   endtask

   initial begin
      conv_request_type r;
      sb = new();
      reset     <= 1'b1;
      start     <= 1'b0;
      req_bus   <= '0;
      csr_valid <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // --- directed part, defaults after reset: 256 x 256, no taps applied ---
      // full kernel table first so no tap is ever read unwritten
      issue_tap(0, 4'sd0, 4'sd0, 16'sh7FFF);    // largest positive weight
      issue_tap(1, 4'sd0, 4'sd0, 16'sh8000);    // largest negative weight
      issue_tap(2, -4'sd8, 4'sd7, 16'sh0100);   // -8 offset saturates to -7
      issue_tap(3, 4'sd7, -4'sd8, -16'sh0100);
      issue_tap(4, -4'sd7, -4'sd7, 16'sh0001);
      for (int t = 5; t < MAX_TAPS; t++)
         issue_tap(t, OFF_W'($urandom), OFF_W'($urandom), random_weight());
      r         = random_request();
      r.command = CMD_UNUSED;                   // unknown command, no response
      send_request(r);
      issue_compute(0, 0);                      // no taps: result is zero
      issue_compute(255, 255);
      issue_pixel(255, 255, 8'd255);
      issue_pixel(0, 0, 8'd0);

      // single tap of weight just under 128.0 on a white pixel saturates high
      program_regs(9'd256, 9'd256, 9'd1, 1'b0);
      issue_compute(255, 255);
      issue_compute(0, 0);
      // adding the -128.0 tap drives the sum negative, which clamps to zero
      program_regs(9'd256, 9'd256, 9'd2, 1'b1);
      issue_compute(255, 255);

      // --- random part across register settings, extremes among them ---
      random_items(70, 1'b1);
      program_regs(9'd8, 9'd8, 9'd5, 1'b0);
      random_items(110, 1'b1);
      program_regs(9'd1, 9'd1, 9'd16, 1'b0);      // one-pixel image, full kernel
      random_items(50, 1'b1);
      program_regs(9'd0, 9'd37, 9'd4, 1'b1);      // zero width: every tap off-image
      random_items(40, 1'b1);
      program_regs(9'd511, 9'd300, 9'd31, 1'b0); // over-range values act as the maxima
      random_items(130, 1'b1);
      program_regs(9'd16, 9'd12, 9'd16, 1'b0);
      random_items(140, 1'b1);
      program_regs(9'd3, 9'd256, 9'd1, 1'b0);
      random_items(50, 1'b1);
      program_regs(9'd256, 9'd1, 9'd0, 1'b1);
      random_items(30, 1'b1);
      program_regs(9'd20, 9'd20, 9'h1F0, 1'b0);  // upper data bits dropped: 16 taps
      random_items(90, 1'b1);
      // closing stretch runs flat out, no sender gaps
      program_regs(9'd6, 9'd7, 9'd9, 1'b1);
      random_items(110, 1'b0);

      settle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.pending() != 0)
         sb.report($sformatf("%0d computes never answered", sb.pending()));
      if (sb.error_count == 0)
         $display("[sparse_kernel_image_convolution_core] OK");
      else
         $display("[sparse_kernel_image_convolution_core] ERROR");
      $finish;
   end

endmodule

@@ sparse_kernel_image_convolution_core.f @@
+incdir+hw/rtl
hw/rtl/skic_pkg.sv
hw/rtl/skic_ram.sv
hw/rtl/skic_ctrl.sv
hw/rtl/skic_accum.sv
hw/rtl/sparse_kernel_image_convolution_core.sv
hw/rtl/skic_checker.sv
dv/tb_sparse_kernel_image_convolution_core.sv
